// File: sv/rgp_pkg.sv
// ----------------------------------------------------------------------------
// Routing graph planner package
// Shared types and codes of the planner: edge format, check result, states.
// ----------------------------------------------------------------------------
package rgp_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_SELF     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_CYCLE    = 3'd4;
  localparam logic [2:0] ST_DISCONN  = 3'd5;
  localparam logic [2:0] ST_NO_OUT   = 3'd6;

  typedef struct packed {
    logic       src_in;
    logic [3:0] src;
    logic       dst_out;
    logic [3:0] dst;
  } edge_t;

  typedef struct packed {
    logic       err;
    logic [2:0] code;
    logic [3:0] node;
  } chk_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CHECK,
    S_DEG,
    S_INIT,
    S_KSEL,
    S_KSCAN,
    S_PROP,
    S_VERIFY,
    S_EMIT,
    S_ERR
  } state_e;

endpackage

// File: sv/rgp_edge_mem.sv
// ----------------------------------------------------------------------------
// Routing graph planner edge memory
// Single write port, single registered read port edge store.
// ----------------------------------------------------------------------------
module rgp_edge_mem #(
  parameter int Depth = 64,
  parameter int AW    = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  rgp_pkg::edge_t  wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output rgp_pkg::edge_t  rdata_o
);
  import rgp_pkg::*;

  edge_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: sv/rgp_edge_unit.sv
// ----------------------------------------------------------------------------
// Routing graph planner edge checker
// Checks one edge for unknown node indices and for a self-edge.
// ----------------------------------------------------------------------------
module rgp_edge_unit #(
  parameter int NW = 5
) (
  input  rgp_pkg::edge_t edge_i,
  input  logic [NW-1:0]  n_i,
  output rgp_pkg::chk_t  chk_o
);
  import rgp_pkg::*;

  localparam int CMPW = (NW > 4) ? NW : 4;

  logic src_bad;
  logic dst_bad;

  assign src_bad = !edge_i.src_in  && (CMPW'(edge_i.src) >= CMPW'(n_i));
  assign dst_bad = !edge_i.dst_out && (CMPW'(edge_i.dst) >= CMPW'(n_i));

  always_comb begin
    chk_o = '{err: 1'b0, code: ST_OK, node: 4'd0};
    if (src_bad) begin
      chk_o = '{err: 1'b1, code: ST_UNKNOWN, node: edge_i.src};
    end else if (dst_bad) begin
      chk_o = '{err: 1'b1, code: ST_UNKNOWN, node: edge_i.dst};
    end else if (!edge_i.src_in && !edge_i.dst_out && (edge_i.src == edge_i.dst)) begin
      chk_o = '{err: 1'b1, code: ST_SELF, node: edge_i.src};
    end
  end

endmodule

// File: sv/routing_graph_planner.sv
// ----------------------------------------------------------------------------
// Routing graph planner
// Loads routing edges, sorts the node graph topologically and checks routes.
// ----------------------------------------------------------------------------
// Usage: each transaction on the input side is one edge, offered on the edge
// ports with start_i while busy_o is low. An edge without last_edge_i
// produces nothing and busy_o stays low. The edge with last_edge_i
// starts planning, and busy_o stays high until the plan has been delivered.
// Results come out with result_valid_o high for one cycle each: either the
// execution order (one node per cycle, the last one flagged) or a single
// status result naming the first error. The receiver cannot stall; results
// are simply presented one per cycle.
// Planning with n nodes runs the edge recheck, degree counting, queue
// seeding, the Kahn walk (one scan of all edges per queued node), the
// propagation passes of the reachability check (at most n passes) and the
// final route check, then the output. Every edge-based step reads the edge
// memory through its single read port, one edge per cycle, and that port
// sets the pace. Reset clears all control state, sets node_count to 1 and
// empties the edge list; no clearing pass is needed. The user must write
// the node_count register through cfg_we_i only while the block idles;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module routing_graph_planner #(
  parameter int MAX_NODES = 16,
  parameter int MAX_EDGES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       source_is_input_i,
  input  logic [3:0] source_node_i,
  input  logic       dest_is_output_i,
  input  logic [3:0] dest_node_i,
  input  logic       last_edge_i,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  output logic       result_valid_o,
  output logic [3:0] out_node_o,
  output logic [2:0] status_o,
  output logic       last_result_o
);
  import rgp_pkg::*;

  // Widths of node counts, node indices, edge counts and edge addresses.
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int DW  = EW;

  state_e state_q, state_d;

  logic [4:0]    nc_q, nc_d;
  logic [EW-1:0] total_q, total_d;
  logic [2:0]    ferr_q, ferr_d;
  logic [3:0]    enode_q, enode_d;
  logic [EW-1:0] e_q, e_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] head_q, head_d;
  logic [CW-1:0] tail_q, tail_d;
  logic [3:0]    u_q, u_d;
  logic          changed_q, changed_d;
  logic [DW-1:0] indeg_q [MAX_NODES];
  logic [DW-1:0] indeg_d [MAX_NODES];
  logic [3:0]    queue_q [MAX_NODES];
  logic [3:0]    queue_d [MAX_NODES];
  logic [MAX_NODES-1:0] from_q, from_d;
  logic [MAX_NODES-1:0] to_q, to_d;

  logic       rv_q, rv_d;
  logic [3:0] on_q, on_d;
  logic [2:0] st_q, st_d;
  logic       lr_q, lr_d;

  // Effective node count: zero acts as one, large values clip.
  logic [CW-1:0] n_eff;
  always_comb begin
    if (nc_q == 5'd0) begin
      n_eff = CW'(1);
    end else if (32'(nc_q) > MAX_NODES) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(nc_q);
    end
  end

  // Edge memory: written while loading, scanned by the edge-based planning steps.
  edge_t   in_edge;
  edge_t   rd_edge;
  logic    mem_we;
  assign in_edge = '{src_in: source_is_input_i, src: source_node_i,
                     dst_out: dest_is_output_i, dst: dest_node_i};

  rgp_edge_mem #(.Depth(MAX_EDGES), .AW(AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(total_q[AW-1:0]),
    .wdata_i(in_edge),
    .raddr_i(e_d[AW-1:0]),
    .rdata_o(rd_edge)
  );

  // One checker serves both the incoming edge and the stored-edge recheck.
  edge_t chk_edge;
  chk_t  chk;
  assign chk_edge = (state_q == S_IDLE) ? in_edge : rd_edge;

  rgp_edge_unit #(.NW(CW)) u_chk (
    .edge_i(chk_edge),
    .n_i   (n_eff),
    .chk_o (chk)
  );

  logic accept;
  logic e_end;
  logic nn_edge;
  assign accept  = start_i && (state_q == S_IDLE);
  assign e_end   = (e_q == total_q);
  assign nn_edge = !rd_edge.src_in && !rd_edge.dst_out;

  // Single read index per small array.
  logic [NIW-1:0] deg_idx;
  logic [DW-1:0]  deg_rd;
  logic [DW-1:0]  deg_dec;
  logic [3:0]     q_rd;
  assign deg_idx = (state_q == S_INIT) ? NIW'(i_q) : NIW'(rd_edge.dst);
  assign deg_rd  = indeg_q[deg_idx];
  assign deg_dec = deg_rd - DW'(1);
  assign q_rd    = queue_q[NIW'(head_q)];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept && last_edge_i) state_d = S_START;
      S_START:  state_d = S_CHECK;
      S_CHECK: begin
        if (ferr_q != ST_OK) state_d = S_ERR;
        else if (e_end) state_d = S_DEG;
      end
      S_DEG:    if (e_end) state_d = S_INIT;
      S_INIT:   if (i_q == n_eff) state_d = S_KSEL;
      S_KSEL: begin
        if (head_q == tail_q) state_d = (tail_q != n_eff) ? S_ERR : S_PROP;
        else state_d = S_KSCAN;
      end
      S_KSCAN:  if (e_end) state_d = S_KSEL;
      S_PROP:   if (e_end && !changed_q) state_d = S_VERIFY;
      S_VERIFY: begin
        if (i_q == n_eff) state_d = S_EMIT;
        else if (!from_q[NIW'(i_q)] || !to_q[NIW'(i_q)]) state_d = S_ERR;
      end
      S_EMIT:   if (head_q + CW'(1) == n_eff) state_d = S_IDLE;
      S_ERR:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and result registers.
  always_comb begin
    nc_d      = cfg_we_i ? cfg_wdata_i : nc_q;
    total_d   = total_q;
    ferr_d    = ferr_q;
    enode_d   = enode_q;
    e_d       = e_q;
    i_d       = i_q;
    head_d    = head_q;
    tail_d    = tail_q;
    u_d       = u_q;
    changed_d = changed_q;
    indeg_d   = indeg_q;
    queue_d   = queue_q;
    from_d    = from_q;
    to_d      = to_q;
    mem_we    = 1'b0;
    rv_d      = 1'b0;
    on_d      = on_q;
    st_d      = st_q;
    lr_d      = lr_q;

    unique case (state_q)
      S_IDLE: begin
        e_d = '0;
        if (accept && (ferr_q == ST_OK)) begin
          if (chk.err) begin
            ferr_d  = chk.code;
            enode_d = chk.node;
          end else if (total_q == EW'(MAX_EDGES)) begin
            ferr_d  = ST_OVERFLOW;
            enode_d = 4'd0;
          end else begin
            mem_we  = 1'b1;
            total_d = total_q + EW'(1);
          end
        end
      end
      S_START: begin
        e_d = '0;
        for (int k = 0; k < MAX_NODES; k++) indeg_d[k] = '0;
        from_d = '0;
        to_d   = '0;
      end
      S_CHECK: begin
        if (ferr_q == ST_OK && e_end) begin
          e_d = '0;
        end else if (ferr_q == ST_OK) begin
          if (chk.err) begin
            ferr_d  = chk.code;
            enode_d = chk.node;
          end
          e_d = e_q + EW'(1);
        end
      end
      S_DEG: begin
        if (e_end) begin
          i_d    = '0;
          tail_d = '0;
        end else begin
          if (nn_edge) indeg_d[NIW'(rd_edge.dst)] = deg_rd + DW'(1);
          if (rd_edge.src_in && !rd_edge.dst_out) from_d[NIW'(rd_edge.dst)] = 1'b1;
          if (rd_edge.dst_out && !rd_edge.src_in) to_d[NIW'(rd_edge.src)] = 1'b1;
          e_d = e_q + EW'(1);
        end
      end
      S_INIT: begin
        e_d = '0;
        if (i_q == n_eff) begin
          head_d = '0;
        end else begin
          if (deg_rd == '0) begin
            queue_d[NIW'(tail_q)] = 4'(i_q);
            tail_d = tail_q + CW'(1);
          end
          i_d = i_q + CW'(1);
        end
      end
      S_KSEL: begin
        e_d       = '0;
        changed_d = 1'b0;
        if (head_q == tail_q) begin
          if (tail_q != n_eff) begin
            ferr_d  = ST_CYCLE;
            enode_d = 4'd0;
          end
        end else begin
          u_d    = q_rd;
          head_d = head_q + CW'(1);
        end
      end
      S_KSCAN: begin
        if (!e_end) begin
          if (nn_edge && (rd_edge.src == u_q) && (deg_rd != '0)) begin
            indeg_d[NIW'(rd_edge.dst)] = deg_dec;
            if (deg_dec == '0 && tail_q < CW'(MAX_NODES)) begin
              queue_d[NIW'(tail_q)] = rd_edge.dst;
              tail_d = tail_q + CW'(1);
            end
          end
          e_d = e_q + EW'(1);
        end
      end
      S_PROP: begin
        if (e_end) begin
          e_d       = '0;
          changed_d = 1'b0;
          i_d       = '0;
        end else begin
          if (nn_edge) begin
            if (from_q[NIW'(rd_edge.src)] && !from_q[NIW'(rd_edge.dst)]) begin
              from_d[NIW'(rd_edge.dst)] = 1'b1;
              changed_d = 1'b1;
            end
            if (to_q[NIW'(rd_edge.dst)] && !to_q[NIW'(rd_edge.src)]) begin
              to_d[NIW'(rd_edge.src)] = 1'b1;
              changed_d = 1'b1;
            end
          end
          e_d = e_q + EW'(1);
        end
      end
      S_VERIFY: begin
        if (i_q == n_eff) begin
          head_d = '0;
        end else if (!from_q[NIW'(i_q)]) begin
          ferr_d  = ST_DISCONN;
          enode_d = 4'(i_q);
        end else if (!to_q[NIW'(i_q)]) begin
          ferr_d  = ST_NO_OUT;
          enode_d = 4'(i_q);
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      S_EMIT: begin
        rv_d   = 1'b1;
        on_d   = q_rd;
        st_d   = ST_OK;
        lr_d   = (head_q + CW'(1) == n_eff);
        head_d = head_q + CW'(1);
        if (head_q + CW'(1) == n_eff) begin
          total_d = '0;
          ferr_d  = ST_OK;
          enode_d = 4'd0;
        end
      end
      S_ERR: begin
        rv_d    = 1'b1;
        on_d    = enode_q;
        st_d    = ferr_q;
        lr_d    = 1'b1;
        total_d = '0;
        ferr_d  = ST_OK;
        enode_d = 4'd0;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      nc_q      <= 5'd1;
      total_q   <= '0;
      ferr_q    <= ST_OK;
      enode_q   <= 4'd0;
      e_q       <= '0;
      i_q       <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      changed_q <= 1'b0;
      from_q    <= '0;
      to_q      <= '0;
      rv_q      <= 1'b0;
      for (int k = 0; k < MAX_NODES; k++) indeg_q[k] <= '0;
    end else begin
      state_q   <= state_d;
      nc_q      <= nc_d;
      total_q   <= total_d;
      ferr_q    <= ferr_d;
      enode_q   <= enode_d;
      e_q       <= e_d;
      i_q       <= i_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      changed_q <= changed_d;
      from_q    <= from_d;
      to_q      <= to_d;
      rv_q      <= rv_d;
      indeg_q   <= indeg_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    queue_q <= queue_d;
    on_q    <= on_d;
    st_q    <= st_d;
    lr_q    <= lr_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign out_node_o     = on_q;
  assign status_o       = st_q;
  assign last_result_o  = lr_q;

endmodule
